// File: hdl/dllm_pkg.sv
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and constants of the doubly linked list manager: command and
// status codes, sequencer states, field widths and the result record.
// ----------------------------------------------------------------------------
package dllm_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int ITEM_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = ((POS_W + ITEM_W + 7) / 8) * 8;
	localparam int M_FIELD_W = ITEM_W + COUNT_W + STATUS_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_HEAD  = 3'd0,
		CMD_ADD_TAIL  = 3'd1,
		CMD_TAKE_HEAD = 3'd2,
		CMD_TAKE_TAIL = 3'd3,
		CMD_INSERT    = 3'd4,
		CMD_REMOVE    = 3'd5,
		CMD_LIST_FWD  = 3'd6,
		CMD_LIST_BWD  = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_ALLOC_RD,
		S_LINK_A,
		S_LINK_B,
		S_WALK,
		S_WALK_STEP,
		S_AT_RD,
		S_AT_DATA,
		S_UNLINK_A,
		S_UNLINK_B,
		S_LIST_RD,
		S_LIST_EMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ITEM_W-1:0]   item_out;
		logic                has_item;
		logic                last;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// File: hdl/dllm_ram.sv
// ----------------------------------------------------------------------------
// dllm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dllm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/dllm_out.sv
// ----------------------------------------------------------------------------
// dllm_out
// Result register in front of the master stream port. Holds one result until
// the downstream side takes it and reports when the slot can be loaded.
// ----------------------------------------------------------------------------
module dllm_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  dllm_pkg::result_t                  res,
	output logic                               slot_free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: item_out[31:0], count[38:32], status[40:39], zero pad
	output logic [dllm_pkg::M_TDATA_W-1:0]     m_tdata,
	// m_tuser: has_item
	output logic                               m_tuser,
	output logic                               m_tlast
);

	localparam int PAD_W = dllm_pkg::M_TDATA_W - dllm_pkg::M_FIELD_W;

	logic              valid_q;
	dllm_pkg::result_t res_q;

	assign slot_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, res_q.status, res_q.count, res_q.item_out};
	assign m_tuser  = res_q.has_item;
	assign m_tlast  = res_q.last;

endmodule

// File: hdl/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Ordered list of signed 32-bit values in a node store with forward and
// backward links, driven by push, pop, insert, remove and listing commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the sequencer
// is idle. Every step goes through the registered read port of the node
// RAMs, one access a cycle. A push allocates a node, reading the free
// chain first when a removed node is reused, and links it in; a pop
// unlinks an end node; insert and remove walk forward links from the head
// to the position first; a listing reads its elements in turn; a refused
// or ignored command or an empty listing goes to its result. A result that
// finds the output register still occupied holds the sequencer until the
// downstream side takes it. Each command gives one result, except a listing
// of a non-empty list, which gives one result per element with tlast on the
// final one. Results wait in an output register, so the next command is
// taken while a result is still pending. No clearing pass runs after reset:
// never-used nodes are handed out from a fill counter, and removed nodes are
// kept on a free chain that is drawn from first.
module doubly_linked_list_manager #(
	parameter int CAPACITY = dllm_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: position[6:0], item_in[38:7], zero pad
	input  logic [dllm_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: command
	input  logic [dllm_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: item_out[31:0], count[38:32], status[40:39], zero pad
	output logic [dllm_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser: has_item
	output logic                           m_tuser,
	output logic                           m_tlast
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = dllm_pkg::POS_W;
	localparam int IW = dllm_pkg::ITEM_W;
	localparam int CW = (LW > PW) ? LW : PW;
	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
	localparam logic [LW-1:0] LINK_ONE  = LW'(1);
	localparam logic [PW-1:0] IDX_ONE   = PW'(1);

	function automatic logic is_node(input logic [LW-1:0] n);
		return n < NULL_LINK;
	endfunction

	// input fields
	dllm_pkg::cmd_t  cmd_in;
	logic [PW-1:0]   pos_in;
	logic [IW-1:0]   item_in;

	assign cmd_in  = dllm_pkg::cmd_t'(s_tuser);
	assign pos_in  = s_tdata[PW-1:0];
	assign item_in = s_tdata[PW+IW-1:PW];

	dllm_pkg::state_t  state_q, state_d;
	dllm_pkg::cmd_t    cmd_q, cmd_d;
	dllm_pkg::status_t st_q, st_d;
	logic [PW-1:0]     idx_q, idx_d;
	logic [IW-1:0]     val_q, val_d;
	logic [LW-1:0]     cur_q, cur_d;
	logic [LW-1:0]     at_q, at_d;
	logic [LW-1:0]     before_q, before_d;
	logic [LW-1:0]     new_q, new_d;
	logic [LW-1:0]     head_q, head_d;
	logic [LW-1:0]     tail_q, tail_d;
	logic [LW-1:0]     rfree_q, rfree_d;
	logic [LW-1:0]     fresh_q, fresh_d;
	logic [LW-1:0]     count_q, count_d;

	logic              full;
	logic [LW-1:0]     list_link;

	// node RAM ports, one read address shared by all three
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              val_we;
	logic [AW-1:0]     val_waddr;
	logic [IW-1:0]     val_wdata;
	logic [IW-1:0]     val_rdata;
	logic              nxt_we;
	logic [AW-1:0]     nxt_waddr;
	logic [LW-1:0]     nxt_wdata;
	logic [LW-1:0]     nxt_rdata;
	logic              prv_we;
	logic [AW-1:0]     prv_waddr;
	logic [LW-1:0]     prv_wdata;
	logic [LW-1:0]     prv_rdata;

	logic              res_load;
	logic              slot_free;
	dllm_pkg::result_t res;

	assign full      = count_q >= NULL_LINK;
	assign list_link = (cmd_q == dllm_pkg::CMD_LIST_FWD) ? nxt_rdata : prv_rdata;
	assign s_tready  = (state_q == dllm_pkg::S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		st_d      = st_q;
		idx_d     = idx_q;
		val_d     = val_q;
		cur_d     = cur_q;
		at_d      = at_q;
		before_d  = before_q;
		new_d     = new_q;
		head_d    = head_q;
		tail_d    = tail_q;
		rfree_d   = rfree_q;
		fresh_d   = fresh_q;
		count_d   = count_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q[AW-1:0];
		val_we    = 1'b0;
		val_waddr = new_q[AW-1:0];
		val_wdata = val_q;
		nxt_we    = 1'b0;
		nxt_waddr = new_q[AW-1:0];
		nxt_wdata = at_q;
		prv_we    = 1'b0;
		prv_waddr = new_q[AW-1:0];
		prv_wdata = before_q;
		res_load  = 1'b0;
		res       = '0;
		res.count = dllm_pkg::COUNT_W'(count_q);

		case (state_q)
			dllm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					cmd_d = cmd_in;
					idx_d = pos_in;
					val_d = item_in;
					cur_d = head_q;
					st_d  = dllm_pkg::ST_DONE;
					case (cmd_in)
						dllm_pkg::CMD_ADD_HEAD, dllm_pkg::CMD_ADD_TAIL: begin
							if (full) begin
								st_d    = dllm_pkg::ST_FULL;
								state_d = dllm_pkg::S_DONE;
							end else begin
								at_d     = (cmd_in == dllm_pkg::CMD_ADD_HEAD) ?
									head_q : NULL_LINK;
								before_d = (cmd_in == dllm_pkg::CMD_ADD_HEAD) ?
									NULL_LINK : tail_q;
								state_d  = dllm_pkg::S_ALLOC;
							end
						end
						dllm_pkg::CMD_TAKE_HEAD, dllm_pkg::CMD_TAKE_TAIL: begin
							cur_d = (cmd_in == dllm_pkg::CMD_TAKE_HEAD) ? head_q : tail_q;
							if (!is_node(cur_d)) begin
								st_d    = dllm_pkg::ST_IGNORED;
								state_d = dllm_pkg::S_DONE;
							end else begin
								state_d = dllm_pkg::S_AT_RD;
							end
						end
						dllm_pkg::CMD_INSERT: begin
							if (CW'(pos_in) > CW'(count_q)) begin
								st_d    = dllm_pkg::ST_IGNORED;
								state_d = dllm_pkg::S_DONE;
							end else if (full) begin
								st_d    = dllm_pkg::ST_FULL;
								state_d = dllm_pkg::S_DONE;
							end else begin
								state_d = dllm_pkg::S_WALK;
							end
						end
						dllm_pkg::CMD_REMOVE: begin
							if (CW'(pos_in) >= CW'(count_q)) begin
								st_d    = dllm_pkg::ST_IGNORED;
								state_d = dllm_pkg::S_DONE;
							end else begin
								state_d = dllm_pkg::S_WALK;
							end
						end
						default: begin
							// listing: start at either end
							cur_d = (cmd_in == dllm_pkg::CMD_LIST_FWD) ? head_q : tail_q;
							state_d = is_node(cur_d) ? dllm_pkg::S_LIST_RD : dllm_pkg::S_DONE;
						end
					endcase
				end
			end

			dllm_pkg::S_ALLOC: begin
				if (is_node(rfree_q)) begin
					// reuse a removed node and advance the free chain
					new_d   = rfree_q;
					rd_en   = 1'b1;
					rd_addr = rfree_q[AW-1:0];
					state_d = dllm_pkg::S_ALLOC_RD;
				end else begin
					new_d   = fresh_q;
					fresh_d = fresh_q + LINK_ONE;
					state_d = dllm_pkg::S_LINK_A;
				end
			end

			dllm_pkg::S_ALLOC_RD: begin
				rfree_d = nxt_rdata;
				state_d = dllm_pkg::S_LINK_A;
			end

			dllm_pkg::S_LINK_A: begin
				val_we  = 1'b1;
				nxt_we  = 1'b1;
				prv_we  = 1'b1;
				state_d = dllm_pkg::S_LINK_B;
			end

			dllm_pkg::S_LINK_B: begin
				if (is_node(before_q)) begin
					nxt_we    = 1'b1;
					nxt_waddr = before_q[AW-1:0];
					nxt_wdata = new_q;
				end else begin
					head_d = new_q;
				end
				if (is_node(at_q)) begin
					prv_we    = 1'b1;
					prv_waddr = at_q[AW-1:0];
					prv_wdata = new_q;
				end else begin
					tail_d = new_q;
				end
				count_d = count_q + LINK_ONE;
				state_d = dllm_pkg::S_DONE;
			end

			dllm_pkg::S_WALK: begin
				if (idx_q == '0) begin
					state_d = dllm_pkg::S_AT_RD;
				end else begin
					rd_en   = 1'b1;
					state_d = dllm_pkg::S_WALK_STEP;
				end
			end

			dllm_pkg::S_WALK_STEP: begin
				// follow one forward link per cycle
				cur_d = nxt_rdata;
				idx_d = idx_q - IDX_ONE;
				if (idx_q == IDX_ONE) begin
					state_d = dllm_pkg::S_AT_RD;
				end else begin
					rd_en   = 1'b1;
					rd_addr = nxt_rdata[AW-1:0];
				end
			end

			dllm_pkg::S_AT_RD: begin
				rd_en   = is_node(cur_q);
				state_d = (cmd_q == dllm_pkg::CMD_INSERT) ? dllm_pkg::S_AT_DATA :
					dllm_pkg::S_UNLINK_A;
			end

			dllm_pkg::S_AT_DATA: begin
				at_d     = cur_q;
				before_d = is_node(cur_q) ? prv_rdata : tail_q;
				state_d  = dllm_pkg::S_ALLOC;
			end

			dllm_pkg::S_UNLINK_A: begin
				// bridge the neighbors of the node at cur_q
				if (is_node(prv_rdata)) begin
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata[AW-1:0];
					nxt_wdata = nxt_rdata;
				end else begin
					head_d = nxt_rdata;
				end
				if (is_node(nxt_rdata)) begin
					prv_we    = 1'b1;
					prv_waddr = nxt_rdata[AW-1:0];
					prv_wdata = prv_rdata;
				end else begin
					tail_d = prv_rdata;
				end
				state_d = dllm_pkg::S_UNLINK_B;
			end

			dllm_pkg::S_UNLINK_B: begin
				nxt_we    = 1'b1;
				nxt_waddr = cur_q[AW-1:0];
				nxt_wdata = rfree_q;
				rfree_d   = cur_q;
				count_d   = count_q - LINK_ONE;
				state_d   = dllm_pkg::S_DONE;
			end

			dllm_pkg::S_LIST_RD: begin
				rd_en   = 1'b1;
				state_d = dllm_pkg::S_LIST_EMIT;
			end

			dllm_pkg::S_LIST_EMIT: begin
				if (slot_free) begin
					res_load     = 1'b1;
					res.item_out = val_rdata;
					res.has_item = 1'b1;
					res.last     = !is_node(list_link);
					res.status   = dllm_pkg::ST_DONE;
					if (!is_node(list_link)) begin
						state_d = dllm_pkg::S_IDLE;
					end else begin
						cur_d   = list_link;
						rd_en   = 1'b1;
						rd_addr = list_link[AW-1:0];
					end
				end
			end

			dllm_pkg::S_DONE: begin
				if (slot_free) begin
					res_load   = 1'b1;
					res.last   = 1'b1;
					res.status = st_q;
					state_d    = dllm_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = dllm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dllm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_LINK;
			tail_q  <= NULL_LINK;
			rfree_q <= NULL_LINK;
			fresh_q <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			rfree_q <= rfree_d;
			fresh_q <= fresh_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		st_q     <= st_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		cur_q    <= cur_d;
		at_q     <= at_d;
		before_q <= before_d;
		new_q    <= new_d;
	end

	dllm_ram #(
		.WIDTH (IW),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	dllm_ram #(
		.WIDTH (LW),
		.DEPTH (CAPACITY)
	) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (nxt_rdata)
	);

	dllm_ram #(
		.WIDTH (LW),
		.DEPTH (CAPACITY)
	) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (prv_rdata)
	);

	dllm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NULL_LINK)
		else $error("element count above capacity");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dllm_pkg::S_IDLE |-> ((count_q == '0) == !is_node(head_q)))
		else $error("head link disagrees with element count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dllm_pkg::S_IDLE |-> ((count_q == '0) == !is_node(tail_q)))
		else $error("tail link disagrees with element count");

	a_fresh_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dllm_pkg::S_IDLE && !is_node(rfree_q)) |-> (fresh_q == count_q))
		else $error("node accounting lost a node");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> slot_free)
		else $error("result loaded over a pending result");

endmodule
